// File: rtl/golden_section_minimizer_top_assert.svh
// ----------------------------------------------------------------------------
// Golden-section minimizer assertion macros
// Small concurrent assertion helpers used by the top-level RTL of the minimizer.
// ----------------------------------------------------------------------------
`ifndef GOLDEN_SECTION_MINIMIZER_TOP_ASSERT_SVH
`define GOLDEN_SECTION_MINIMIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define GSM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("gsm assertion failed: invariant");

// Consequence that must hold in the same cycle as the antecedent.
`define GSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsm assertion failed: implication");

// Consequence that must hold in the cycle after the antecedent.
`define GSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gsm assertion failed: next-cycle implication");

`else

`define GSM_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define GSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/gsm_pkg.sv
// ----------------------------------------------------------------------------
// Golden-section minimizer package
// Widths, register indexes, beat types and sequencer states of the minimizer.
// ----------------------------------------------------------------------------
package gsm_pkg;

    // All values are signed Q16.16 in a 32-bit word.
    localparam int unsigned DATA_WIDTH      = 32;
    localparam int unsigned TOL_WIDTH       = DATA_WIDTH - 1;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    // Step ratio (sqrt5-1)/(sqrt5+1) with 32 fraction bits.
    localparam int unsigned            GOLDEN_FRAC_BITS  = 32;
    localparam logic [GOLDEN_FRAC_BITS-1:0] GOLDEN_RATIO_FRAC = 32'h61C8_8647;

    localparam int unsigned MAX_ITERATIONS_DEFAULT = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LINEAR_COEF = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE   = 2'd1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] left_bound;
        logic signed [DATA_WIDTH-1:0] right_bound;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] best_point;
        logic                         hit_limit;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [DATA_WIDTH-1:0]      data;
    } t_cfg_write;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_STEP,
        S_INIT,
        S_EVAL,
        S_CMP,
        S_UPDATE,
        S_CLAMP,
        S_DONE
    } t_state;

endpackage

// File: rtl/gsm_stream_if.sv
// ----------------------------------------------------------------------------
// Golden-section minimizer stream interface
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface gsm_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/gsm_step_unit.sv
// ----------------------------------------------------------------------------
// Golden-section step unit
// Shared multiplier: step = round(width * 0.381966) with half-up rounding.
// ----------------------------------------------------------------------------
module gsm_step_unit
    import gsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [DATA_WIDTH-1:0] i_width,
    output logic [DATA_WIDTH-1:0] o_step
);

    localparam int unsigned PROD_WIDTH = DATA_WIDTH + GOLDEN_FRAC_BITS;
    localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (GOLDEN_FRAC_BITS - 1);

    logic [PROD_WIDTH-1:0] r_product;
    logic [PROD_WIDTH-1:0] w_rounded;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_product <= PROD_WIDTH'(i_width) * PROD_WIDTH'(GOLDEN_RATIO_FRAC);
        end
    end

    // The product stays well below the top bit, so the rounding add cannot wrap.
    assign w_rounded = r_product + ROUND_HALF;
    assign o_step    = w_rounded[PROD_WIDTH-1:GOLDEN_FRAC_BITS];

endmodule

// File: rtl/golden_section_minimizer_top.sv
// ----------------------------------------------------------------------------
// Golden-section minimizer
// Finds the minimizer of x*x + a*x over a given interval by golden-section
// search on signed Q16.16 values.
// ----------------------------------------------------------------------------
// Each input beat carries a left and a right bound; reversed bounds are
// swapped. The block narrows the interval by round(0.381966 * width) per step
// and keeps the side whose inner point has the smaller objective value, using
// an exact sign test rather than forming any product of x. It stops when the
// width is at most the tolerance register and returns the inner point x1 with
// hit_limit low; if the step rounds to zero or MAX_ITERATIONS steps have been
// taken first, it returns x1 with hit_limit high. A search runs at most
// MAX_ITERATIONS narrowing steps (about 45 for a full-range interval and
// unit tolerance). Each step passes through the sequence S_CMP, S_UPDATE,
// S_CLAMP, S_STEP and S_EVAL around the single shared multiplier that
// computes each step size; the input is not ready during a search. The
// result waits in an output register, so a new search may start while it is
// still unread.
// Configuration (linear_coef at index 0, tolerance at index 1) is always
// ready and must only be written while no search is in flight.
// ----------------------------------------------------------------------------
`include "golden_section_minimizer_top_assert.svh"

module golden_section_minimizer_top
    import gsm_pkg::*;
#(
    parameter int unsigned MAX_ITERATIONS = MAX_ITERATIONS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gsm_stream_if.sink     i_in,
    gsm_stream_if.source   o_out,
    gsm_stream_if.sink     i_cfg
);

    localparam int unsigned ITER_WIDTH = $clog2(MAX_ITERATIONS + 1);
    localparam int unsigned SUM_WIDTH  = DATA_WIDTH + 2;

    // Sequencer and control state.
    t_state                r_state;
    t_state                n_state;
    logic                  r_first;
    logic [ITER_WIDTH-1:0] r_iter;
    logic                  r_out_valid;

    // Configuration registers.
    logic signed [DATA_WIDTH-1:0] r_lin_coef;
    logic [TOL_WIDTH-1:0]         r_tol;

    // Search datapath. Interval points are unsigned offsets from the left bound.
    logic signed [DATA_WIDTH-1:0] r_lb;
    logic signed [DATA_WIDTH-1:0] r_rb;
    logic signed [DATA_WIDTH-1:0] r_lo;
    logic [DATA_WIDTH-1:0]        r_b;
    logic [DATA_WIDTH-1:0]        r_d;
    logic [DATA_WIDTH-1:0]        r_o0;
    logic [DATA_WIDTH-1:0]        r_o1;
    logic [DATA_WIDTH-1:0]        r_o2;
    logic [DATA_WIDTH-1:0]        r_o3;
    logic signed [DATA_WIDTH-1:0] r_x1;
    logic signed [DATA_WIDTH-1:0] r_x2;
    logic                         r_move_left;
    logic                         r_hit;
    t_out_item                    r_out;

    logic                         w_in_accept;
    logic                         w_out_load;
    logic                         w_swap;
    logic                         w_converged;
    logic                         w_stop;
    logic                         w_step_load;
    logic [DATA_WIDTH-1:0]        w_step;
    logic signed [SUM_WIDTH-1:0]  w_sum;
    logic                         w_sum_pos;
    logic                         w_sum_neg;
    logic                         w_move_left;

    function automatic logic [DATA_WIDTH-1:0] clamp_off(
        input logic [DATA_WIDTH-1:0] v,
        input logic [DATA_WIDTH-1:0] lo,
        input logic [DATA_WIDTH-1:0] hi
    );
        logic [DATA_WIDTH-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign i_in.ready    = (r_state == S_IDLE);
    assign w_in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready   = 1'b1;
    assign w_out_load    = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // ------------------------------------------------------------------------
    // Shared step multiplier: loaded with the current width, read on the next cycle.
    // ------------------------------------------------------------------------
    assign w_step_load = (r_state == S_MUL) || (r_state == S_CLAMP);

    gsm_step_unit u_step (
        .i_clk   (i_clk),
        .i_load  (w_step_load),
        .i_width (r_b),
        .o_step  (w_step)
    );

    // ------------------------------------------------------------------------
    // Decisions
    // ------------------------------------------------------------------------
    assign w_swap      = r_lb > r_rb;
    assign w_converged = r_b <= DATA_WIDTH'(r_tol);
    assign w_stop      = w_converged || (r_iter >= ITER_WIDTH'(MAX_ITERATIONS))
                         || (r_d == '0);

    // f(x1) < f(x2) exactly when sign(x1 - x2) * sign(x1 + x2 + a) is negative.
    assign w_sum = SUM_WIDTH'(r_x1) + SUM_WIDTH'(r_x2) + SUM_WIDTH'(r_lin_coef);
    assign w_sum_neg   = w_sum[SUM_WIDTH-1];
    assign w_sum_pos   = !w_sum_neg && (w_sum != '0);
    assign w_move_left = ((r_o1 < r_o2) && w_sum_pos) || ((r_o1 > r_o2) && w_sum_neg);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP:  n_state = S_MUL;
            S_MUL:    n_state = S_STEP;
            S_STEP:   n_state = r_first ? S_INIT : S_EVAL;
            S_INIT:   n_state = S_EVAL;
            S_EVAL:   n_state = w_stop ? S_DONE : S_CMP;
            S_CMP:    n_state = S_UPDATE;
            S_UPDATE: n_state = S_CLAMP;
            S_CLAMP:  n_state = S_STEP;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers: search flags, step count, result valid, configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_lin_coef  <= '0;
            r_tol       <= TOL_WIDTH'(1);
        end else begin
            if (w_in_accept) begin
                r_first <= 1'b1;
                r_iter  <= '0;
            end else if (r_state == S_INIT) begin
                r_first <= 1'b0;
            end else if (r_state == S_UPDATE) begin
                r_iter <= r_iter + ITER_WIDTH'(1);
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.payload.index)
                    CFG_LINEAR_COEF: r_lin_coef <= i_cfg.payload.data;
                    CFG_TOLERANCE:   r_tol      <= i_cfg.payload.data[TOL_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers, stepped by the sequencer state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    r_lb <= i_in.payload.left_bound;
                    r_rb <= i_in.payload.right_bound;
                end
            end
            S_SETUP: begin
                // Width of the interval always fits the unsigned word.
                r_lo <= w_swap ? r_rb : r_lb;
                r_b  <= w_swap ? DATA_WIDTH'(r_lb - r_rb) : DATA_WIDTH'(r_rb - r_lb);
            end
            S_MUL: begin
            end
            S_STEP: begin
                r_d <= w_step;
            end
            S_INIT: begin
                r_o0 <= '0;
                r_o3 <= r_b;
                r_o1 <= r_d;
                r_o2 <= r_b - r_d;
            end
            S_EVAL: begin
                r_x1  <= r_lo + $signed(r_o1);
                r_x2  <= r_lo + $signed(r_o2);
                r_hit <= !w_converged;
            end
            S_CMP: begin
                r_move_left <= w_move_left;
            end
            S_UPDATE: begin
                if (r_move_left) begin
                    // Minimum lies left of x2: drop the right end.
                    r_o2 <= r_o1;
                    r_o3 <= r_o2;
                    r_o1 <= ((r_o2 - r_o0) >= r_d) ? (r_o2 - r_d) : r_o0;
                end else begin
                    // Minimum lies right of x1: drop the left end.
                    r_o1 <= r_o2;
                    r_o0 <= r_o1;
                    r_o2 <= ((r_o3 - r_o1) >= r_d) ? (r_o1 + r_d) : r_o3;
                end
                r_b <= r_b - r_d;
            end
            S_CLAMP: begin
                // Rounding drift could push an inner point outside the interval.
                r_o1 <= clamp_off(r_o1, r_o0, r_o3);
                r_o2 <= clamp_off(r_o2, r_o0, r_o3);
            end
            S_DONE: begin
                if (w_out_load) begin
                    r_out.best_point <= r_lo + $signed(r_o1);
                    r_out.hit_limit  <= r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `GSM_ASSERT_IMPLY(a_points_ordered, i_clk, i_rst_n, (r_state == S_EVAL), (r_o0 <= r_o1 && r_o1 <= r_o3 && r_o0 <= r_o2 && r_o2 <= r_o3))
    `GSM_ASSERT_IMPLY(a_step_within_width, i_clk, i_rst_n, (r_state == S_EVAL && !r_first), (r_d <= r_b))
    `GSM_ASSERT_ALWAYS(a_iter_capped, i_clk, i_rst_n, (r_iter <= ITER_WIDTH'(MAX_ITERATIONS)))
    `GSM_ASSERT_IMPLY(a_clean_stop_converged, i_clk, i_rst_n, (r_state == S_DONE && !r_hit), (r_b <= DATA_WIDTH'(r_tol)))
    `GSM_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (w_out_load), (r_out_valid && r_state == S_IDLE))

endmodule
